[rtl/cr_pkg.sv]
`default_nettype none
package cr_pkg;

    localparam int MAP_DIM_DEF       = 8;
    localparam int TILE_SIZE_DEF     = 64;
    localparam int SCREEN_HEIGHT_DEF = 200;
    localparam int MAX_STEPS_DEF     = 1024;

    localparam int WALL_SCALE = 277;
    localparam int ONE_Q14    = 16384;

    // Ray position in signed Q.14; wide enough for the longest march.
    localparam int POS_W = 28;

    localparam logic [1:0] REG_WALL_MAP   = 2'd0;
    localparam logic [1:0] REG_HALF_FOV   = 2'd1;
    localparam logic [1:0] REG_ANGLE_STEP = 2'd2;

    localparam logic [63:0] RESET_WALL_MAP   = 64'd0;
    localparam logic [14:0] RESET_HALF_FOV   = 15'd5461;
    localparam logic [9:0]  RESET_ANGLE_STEP = 10'd34;

    typedef struct packed {
        logic [16:0] player_x;
        logic [16:0] player_y;
        logic [15:0] player_angle;
        logic [8:0]  column;
    } t_in;

    typedef struct packed {
        logic [8:0] out_column;
        logic       hit;
        logic [6:0] wall_top;
        logic [7:0] wall_height;
        logic [9:0] distance;
    } t_out;

    typedef struct packed {
        logic [8:0]         column;
        logic [16:0]        player_x;
        logic [16:0]        player_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] cos_offset;
    } t_job;

    typedef struct packed {
        logic [63:0] wall_map;
        logic [14:0] half_fov;
        logic [9:0]  angle_step;
    } t_cfg;

    typedef enum logic [2:0] {
        F_IDLE, F_ANGLE, F_COS_RAY, F_SIN_RAY, F_COS_OFF, F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE, B_MARCH, B_MUL, B_CLAMP, B_DIV, B_DONE
    } t_back_state;

endpackage
`default_nettype wire

[rtl/cr_fifo.sv]
`default_nettype none
module cr_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [0:1];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/cr_front.sv]
`default_nettype none
module cr_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire cr_pkg::t_in  i_data,
    output logic              o_stall,
    input  wire cr_pkg::t_cfg i_cfg,
    output logic              o_push,
    output cr_pkg::t_job      o_job,
    input  wire logic         i_full
);

    typedef logic [64:0][14:0] t_rom;

    // Quarter-wave sine table from the integer Chebyshev recurrence.
    function automatic t_rom build_rom();
        t_rom        r;
        logic [63:0] prev, cur, nxt, t;
        r    = '0;
        prev = 64'd0;
        cur  = 64'd26350944;
        for (int k = 1; k <= 64; k++) begin
            t    = (cur + 64'd32768) >> 16;
            r[k] = (t > 64'd16384) ? 15'd16384 : t[14:0];
            nxt  = (64'd2 * 64'd1073418433 * cur + (64'd1 << 29)) >> 30;
            nxt  = (nxt >= prev) ? nxt - prev : 64'd0;
            prev = cur;
            cur  = nxt;
        end
        r[64] = 15'd16384;
        return r;
    endfunction

    localparam t_rom QROM = build_rom();

    function automatic logic signed [15:0] sin16(input logic [15:0] a);
        logic [14:0] t;
        logic [6:0]  i;
        logic [14:0] lo, hi, v;
        logic [22:0] prod;
        t = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        i = t[14:8];
        if (i >= 7'd64) begin
            v = 15'd16384;
        end else begin
            lo   = QROM[i];
            hi   = QROM[i + 7'd1];
            prod = 23'(hi - lo) * 23'(t[7:0]);
            v    = lo + prod[22:8];
        end
        return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    cr_pkg::t_front_state r_state, n_state;
    cr_pkg::t_in          r_in;
    logic [15:0]          r_offset, r_ray;
    logic signed [15:0]   r_dx, r_dy, r_coff;
    logic [15:0]          trig_arg;
    logic signed [15:0]   trig_val;

    always_comb begin
        unique case (r_state)
            cr_pkg::F_COS_RAY: trig_arg = r_ray + 16'd16384;
            cr_pkg::F_SIN_RAY: trig_arg = r_ray;
            default:           trig_arg = r_offset + 16'd16384;
        endcase
        trig_val = sin16(trig_arg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cr_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cr_pkg::F_IDLE: begin
                r_in <= i_data;
            end
            cr_pkg::F_ANGLE: begin
                r_offset <= 16'({1'b0, i_cfg.half_fov})
                          - 16'(r_in.column * i_cfg.angle_step);
                r_ray    <= r_in.player_angle - (16'({1'b0, i_cfg.half_fov})
                          - 16'(r_in.column * i_cfg.angle_step));
            end
            cr_pkg::F_COS_RAY: r_dx <= trig_val;
            cr_pkg::F_SIN_RAY: r_dy <= trig_val;
            cr_pkg::F_COS_OFF: r_coff <= trig_val;
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        o_push  = 1'b0;
        unique case (r_state)
            cr_pkg::F_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = cr_pkg::F_ANGLE;
                end
            end
            cr_pkg::F_ANGLE:   n_state = cr_pkg::F_COS_RAY;
            cr_pkg::F_COS_RAY: n_state = cr_pkg::F_SIN_RAY;
            cr_pkg::F_SIN_RAY: n_state = cr_pkg::F_COS_OFF;
            cr_pkg::F_COS_OFF: n_state = cr_pkg::F_PUSH;
            cr_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = cr_pkg::F_IDLE;
                end
            end
            default: n_state = cr_pkg::F_IDLE;
        endcase
    end

    assign o_job.column     = r_in.column;
    assign o_job.player_x   = r_in.player_x;
    assign o_job.player_y   = r_in.player_y;
    assign o_job.dir_x      = r_dx;
    assign o_job.dir_y      = r_dy;
    assign o_job.cos_offset = r_coff;

endmodule
`default_nettype wire

[rtl/cr_back.sv]
`default_nettype none
module cr_back #(
    parameter int MAP_DIM       = cr_pkg::MAP_DIM_DEF,
    parameter int TILE_SIZE     = cr_pkg::TILE_SIZE_DEF,
    parameter int SCREEN_HEIGHT = cr_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_STEPS     = cr_pkg::MAX_STEPS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_empty,
    input  wire cr_pkg::t_job i_job,
    output logic          o_pop,
    input  wire logic [63:0] i_wall_map,
    output logic          o_valid,
    output cr_pkg::t_out  o_data,
    input  wire logic     i_stall
);

    localparam int PW     = cr_pkg::POS_W;
    localparam int NW     = $clog2(MAX_STEPS + 1);
    localparam int TILE_Q = TILE_SIZE * cr_pkg::ONE_Q14;
    localparam int DW     = 27;
    localparam longint K  = longint'(TILE_SIZE) * cr_pkg::WALL_SCALE * cr_pkg::ONE_Q14;
    localparam int KW     = $clog2(K + 1);
    localparam int CW     = $clog2(KW + 1);
    localparam int HW     = $clog2(SCREEN_HEIGHT + 1);

    localparam logic signed [PW-1:0] NEG_TILE = -PW'(TILE_Q);
    localparam logic signed [PW-1:0] MAP_END  = PW'(MAP_DIM * TILE_Q);

    // Cell along one axis: truncation toward zero puts (-tile, 0) in cell 0.
    function automatic logic [3:0] cell_of(input logic signed [PW-1:0] p);
        logic [3:0] c;
        c = 4'd0;
        if (p <= NEG_TILE || p >= MAP_END) begin
            c = 4'd8;
        end else begin
            for (int k = 1; k < MAP_DIM; k++) begin
                if (p >= $signed(PW'(k * TILE_Q))) begin
                    c = 4'(k);
                end
            end
        end
        return c;
    endfunction

    cr_pkg::t_back_state   r_state, n_state;
    logic [8:0]            r_col;
    logic signed [PW-1:0]  r_rx, r_ry;
    logic signed [15:0]    r_dx, r_dy, r_coff;
    logic [NW-1:0]         r_n;
    logic                  r_hit;
    logic signed [29:0]    r_prod;
    logic [DW-1:0]         r_du, r_rem;
    logic [KW-1:0]         r_quo;
    logic [CW-1:0]         r_cnt;
    logic                  r_out_valid;
    cr_pkg::t_out          r_out;

    logic signed [PW-1:0]  nx, ny;
    logic [3:0]            cx, cy;
    logic [5:0]            widx;
    logic [DW:0]           rs;
    logic                  ge;
    logic [HW-1:0]         h;
    logic [HW-1:0]         top;
    logic                  out_free;

    assign nx   = r_rx + PW'(r_dx);
    assign ny   = r_ry + PW'(r_dy);
    assign cx   = cell_of(nx);
    assign cy   = cell_of(ny);
    assign widx = 6'(32'(cy) * MAP_DIM + 32'(cx));
    assign rs   = {r_rem, r_quo[KW-1]};
    assign ge   = rs >= {1'b0, r_du};
    assign h    = (r_quo > KW'(SCREEN_HEIGHT)) ? HW'(SCREEN_HEIGHT) : HW'(r_quo);
    assign top  = HW'(SCREEN_HEIGHT / 2) - (h >> 1);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            cr_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = cr_pkg::B_MARCH;
                end
            end
            cr_pkg::B_MARCH: begin
                if (cx[3] || cy[3]) begin
                    n_state = cr_pkg::B_DONE;
                end else if (i_wall_map[widx]) begin
                    n_state = cr_pkg::B_MUL;
                end else if (r_n == NW'(MAX_STEPS)) begin
                    n_state = cr_pkg::B_DONE;
                end
            end
            cr_pkg::B_MUL:   n_state = cr_pkg::B_CLAMP;
            cr_pkg::B_CLAMP: n_state = cr_pkg::B_DIV;
            cr_pkg::B_DIV: begin
                if (r_cnt == CW'(KW - 1)) begin
                    n_state = cr_pkg::B_DONE;
                end
            end
            cr_pkg::B_DONE: begin
                if (out_free) begin
                    n_state = cr_pkg::B_IDLE;
                end
            end
            default: n_state = cr_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cr_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cr_pkg::B_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cr_pkg::B_IDLE: begin
                r_col  <= i_job.column;
                r_rx   <= $signed({{(PW-23){1'b0}}, i_job.player_x, 6'd0});
                r_ry   <= $signed({{(PW-23){1'b0}}, i_job.player_y, 6'd0});
                r_dx   <= i_job.dir_x;
                r_dy   <= i_job.dir_y;
                r_coff <= i_job.cos_offset;
                r_n    <= NW'(1);
                r_hit  <= 1'b0;
            end
            cr_pkg::B_MARCH: begin
                r_rx <= nx;
                r_ry <= ny;
                if (!cx[3] && !cy[3] && i_wall_map[widx]) begin
                    r_hit <= 1'b1;
                end else begin
                    r_n <= r_n + NW'(1);
                end
            end
            cr_pkg::B_MUL: begin
                r_prod <= 30'($signed({1'b0, 13'(r_n)}) * r_coff);
            end
            cr_pkg::B_CLAMP: begin
                r_du  <= (r_prod < 30'sd16384) ? DW'(cr_pkg::ONE_Q14) : r_prod[DW-1:0];
                r_rem <= '0;
                r_quo <= KW'(K);
                r_cnt <= '0;
            end
            cr_pkg::B_DIV: begin
                r_rem <= ge ? DW'(rs - {1'b0, r_du}) : rs[DW-1:0];
                r_quo <= {r_quo[KW-2:0], ge};
                r_cnt <= r_cnt + CW'(1);
            end
            cr_pkg::B_DONE: begin
                if (out_free) begin
                    r_out.out_column <= r_col;
                    r_out.hit        <= r_hit;
                    if (r_hit) begin
                        r_out.wall_top    <= top[6:0];
                        r_out.wall_height <= 8'(h);
                        r_out.distance    <= (r_du[DW-1:14] > 13'd1023) ? 10'd1023
                                           : r_du[23:14];
                    end else begin
                        r_out.wall_top    <= 7'd0;
                        r_out.wall_height <= 8'd0;
                        r_out.distance    <= 10'd1023;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

[rtl/column_raycaster_unit.sv]
`default_nettype none
// Flow: angle and trig setup and the queue hand-off, then one march step per cycle
// (up to MAX_STEPS), then multiply, clamp, serial division and output register on a
// hit, or straight to the output register on a miss (the ray left the map or MAX_STEPS
// was reached). Setup of the next column overlaps the march via a 2-entry queue.
// Reset is synchronous, active low; config registers return to their cr_pkg RESET_ values.
module column_raycaster_unit #(
    parameter int MAP_DIM       = cr_pkg::MAP_DIM_DEF,
    parameter int TILE_SIZE     = cr_pkg::TILE_SIZE_DEF,
    parameter int SCREEN_HEIGHT = cr_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_STEPS     = cr_pkg::MAX_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire cr_pkg::t_in i_data,
    output logic             o_stall,
    output logic             o_valid,
    output cr_pkg::t_out     o_data,
    input  wire logic        i_stall,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    cr_pkg::t_cfg r_cfg;
    cr_pkg::t_job push_job, pop_job;
    logic         push, full, pop, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wall_map   <= cr_pkg::RESET_WALL_MAP;
            r_cfg.half_fov   <= cr_pkg::RESET_HALF_FOV;
            r_cfg.angle_step <= cr_pkg::RESET_ANGLE_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cr_pkg::REG_WALL_MAP:   r_cfg.wall_map   <= i_cfg_data;
                cr_pkg::REG_HALF_FOV:   r_cfg.half_fov   <= i_cfg_data[14:0];
                cr_pkg::REG_ANGLE_STEP: r_cfg.angle_step <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    cr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    cr_fifo #(
        .WIDTH ($bits(cr_pkg::t_job))
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (pop_job),
        .o_empty (empty)
    );

    cr_back #(
        .MAP_DIM       (MAP_DIM),
        .TILE_SIZE     (TILE_SIZE),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_STEPS     (MAX_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (pop_job),
        .o_pop      (pop),
        .i_wall_map (r_cfg.wall_map),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

endmodule
`default_nettype wire
